FILE: hw/rtl/pinhole_reprojection_error_top_defines.svh
// assertion macros for the pinhole reprojection error block
// used by the port checker; no other dependencies
`ifndef PINHOLE_REPROJECTION_ERROR_TOP_DEFINES_SVH
`define PINHOLE_REPROJECTION_ERROR_TOP_DEFINES_SVH

// checked outside reset only
`define PRE_CHECK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define PRE_CHECK_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/pre_pkg.sv
// shared types and constants of the pinhole reprojection error block
// no dependencies
package pre_pkg;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 64;
   localparam int COEF_BITS     = 32;
   localparam int ROOT_BITS     = 32;
   localparam int RAD_BITS      = 2 * ROOT_BITS;

   localparam logic [CSR_IDX_BITS-1:0] CSR_K00_K01 = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_K02_K10 = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_K11_K12 = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_K20_K21 = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_K22     = 3'd4;

   typedef struct packed {
      logic        [63:0] stamp;
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] first_z;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic signed [31:0] second_z;
   } req_type;

   typedef struct packed {
      logic [63:0] stamp_out;
      logic [31:0] pixel_error;
      logic        divide_fault;
   } rsp_type;

endpackage

FILE: hw/rtl/pre_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on nothing; stage enables come from the top level
module pre_div #(
   parameter int HW = 66,
   parameter int NW = 82
) (
   input  logic          clock,
   input  logic [NW-1:0] en,
   input  logic [NW-1:0] num,
   input  logic [HW-1:0] den,
   output logic [NW-1:0] quo
);

   logic [NW-1:0] nq_ff  [NW];
   logic [HW-1:0] rem_ff [NW-1];
   logic [HW-1:0] den_ff [NW-1];

   for (genvar g = 0; g < NW; g++) begin : g_stage
      logic [NW-1:0] nq_prev;
      logic [HW-1:0] rem_prev;
      logic [HW-1:0] den_prev;
      logic [HW:0]   shift;
      logic [HW+1:0] diff;
      logic          ge;

      if (g == 0) begin : g_first
         assign nq_prev  = num;
         assign rem_prev = '0;
         assign den_prev = den;
      end else begin : g_next
         assign nq_prev  = nq_ff[g-1];
         assign rem_prev = rem_ff[g-1];
         assign den_prev = den_ff[g-1];
      end

      // bring down the next numerator bit, then trial subtract
      assign shift = {rem_prev, nq_prev[NW-1]};
      assign diff  = {1'b0, shift} - {2'b00, den_prev};
      assign ge    = ~diff[HW+1];

      always_ff @(posedge clock) begin
         if (en[g]) begin
            nq_ff[g] <= {nq_prev[NW-2:0], ge};
         end
      end

      if (g < NW - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (en[g]) begin
               rem_ff[g] <= ge ? diff[HW-1:0] : shift[HW-1:0];
               den_ff[g] <= den_prev;
            end
         end
      end
   end

   assign quo = nq_ff[NW-1];

endmodule

FILE: hw/rtl/pre_sqrt.sv
// pipelined integer square root, one root bit per stage
// depends on pre_pkg for the root and radicand widths
module pre_sqrt (
   input  logic                         clock,
   input  logic [pre_pkg::ROOT_BITS-1:0] en,
   input  logic [pre_pkg::RAD_BITS-1:0]  rad,
   output logic [pre_pkg::ROOT_BITS-1:0] root
);
   import pre_pkg::*;

   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];
   logic [ROOT_BITS:0]   rem_ff  [ROOT_BITS-1];
   logic [RAD_BITS-1:0]  rad_ff  [ROOT_BITS-1];

   for (genvar g = 0; g < ROOT_BITS; g++) begin : g_stage
      logic [ROOT_BITS-1:0] root_prev;
      logic [ROOT_BITS:0]   rem_prev;
      logic [RAD_BITS-1:0]  rad_prev;
      logic [ROOT_BITS+2:0] shift;
      logic [ROOT_BITS+1:0] trial;
      logic [ROOT_BITS+3:0] diff;
      logic                 ge;

      if (g == 0) begin : g_first
         assign root_prev = '0;
         assign rem_prev  = '0;
         assign rad_prev  = rad;
      end else begin : g_next
         assign root_prev = root_ff[g-1];
         assign rem_prev  = rem_ff[g-1];
         assign rad_prev  = rad_ff[g-1];
      end

      // two radicand bits a stage, trial value 4*root+1
      assign shift = {rem_prev, rad_prev[RAD_BITS-1 -: 2]};
      assign trial = {root_prev, 2'b01};
      assign diff  = {1'b0, shift} - {2'b00, trial};
      assign ge    = ~diff[ROOT_BITS+3];

      always_ff @(posedge clock) begin
         if (en[g]) begin
            root_ff[g] <= {root_prev[ROOT_BITS-2:0], ge};
         end
      end

      if (g < ROOT_BITS - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (en[g]) begin
               rem_ff[g] <= ge ? diff[ROOT_BITS:0] : shift[ROOT_BITS:0];
               rad_ff[g] <= rad_prev << 2;
            end
         end
      end
   end

   assign root = root_ff[ROOT_BITS-1];

endmodule

FILE: hw/rtl/pinhole_reprojection_error_top.sv
// pinhole reprojection error, top level: projection, pixel divide, distance
// depends on pre_pkg, pre_div and pre_sqrt
//
//   channel | ports                              | moves
//   --------+------------------------------------+------------------------------
//   request | req_valid, req_stall, req_data     | stamp and two 3d points
//   result  | rsp_valid, rsp_stall, rsp_data     | stamp, pixel distance, fault
//   control | csr_valid, csr_ready, csr_index/da | camera matrix coefficients
//
// one item enters per cycle while req_stall is low; NW = COORD_BITS + 34 + FRAC_BITS
// is the quotient width of the pixel divide, and its one-bit divider stages make up
// most of the pipeline
// reset clears the valid bits and the matrix; payload registers hold junk
// a stall on the result side lets bubbles close up: a stage loads whenever
// some stage at or after it is empty, so items keep entering while the
// output register waits
module pinhole_reprojection_error_top #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  pre_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output pre_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pre_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [pre_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import pre_pkg::*;

   // datapath widths
   localparam int CW = COORD_BITS;        // coordinate
   localparam int PW = CW + COEF_BITS;    // one exact product
   localparam int HW = PW + 2;            // sum of three products
   localparam int NW = HW + FRAC_BITS;    // scaled numerator and quotient
   localparam int QW = NW + 1;            // signed quotient
   localparam int DW = NW + 2;            // quotient difference

   // stage map
   localparam int S_IN  = 0;              // input register
   localparam int S_MUL = 1;              // 18 products
   localparam int S_SUM = 2;              // homogeneous vectors
   localparam int S_ABS = 3;              // magnitudes, signs, zero depth
   localparam int S_DIV = 4;              // first divider stage
   localparam int S_SGN = S_DIV + NW;     // signed pixel coordinates
   localparam int S_DIF = S_SGN + 1;      // dx, dy
   localparam int S_MAG = S_DIF + 1;      // |dx|, |dy|, range check
   localparam int S_SQR = S_MAG + 1;      // squares
   localparam int S_ADD = S_SQR + 1;      // sum of squares
   localparam int S_RT  = S_ADD + 1;      // first root stage
   localparam int S_OUT = S_RT + ROOT_BITS;
   localparam int NS    = S_OUT + 1;

   // stamp and flags that ride along with each item
   typedef struct packed {
      logic [63:0] stamp;
      logic        fault;
      logic        sat;
      logic [3:0]  neg;
   } sb_type;

   // ---------------------------------------------------------------
   // camera matrix registers
   // ---------------------------------------------------------------
   logic [CSR_DATA_BITS-1:0] cam_ff [4];
   logic [COEF_BITS-1:0]     k22_ff;
   logic signed [COEF_BITS-1:0] coef [9];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            cam_ff[i] <= '0;
         end
         k22_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_K00_K01: cam_ff[0] <= csr_data;
            CSR_K02_K10: cam_ff[1] <= csr_data;
            CSR_K11_K12: cam_ff[2] <= csr_data;
            CSR_K20_K21: cam_ff[3] <= csr_data;
            CSR_K22:     k22_ff    <= csr_data[COEF_BITS-1:0];
            default: ;   // writes past the last register are dropped
         endcase
      end
   end

   // row-major coefficients, two per register (one in the K22 register), low half first
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         coef[2*i]   = $signed(cam_ff[i][COEF_BITS-1:0]);
         coef[2*i+1] = $signed(cam_ff[i][2*COEF_BITS-1:COEF_BITS]);
      end
      coef[8] = $signed(k22_ff);
   end

   // ---------------------------------------------------------------
   // valid bits and stage enables
   // ---------------------------------------------------------------
   logic [NS-1:0] v_ff, v_in, en;
   logic          out_rdy;

   assign out_rdy = ~v_ff[NS-1] | ~rsp_stall;

   // a stage may load when the output drains or any stage at or after it is empty
   for (genvar g = 0; g < NS; g++) begin : g_en
      assign en[g] = out_rdy | ~(&v_ff[NS-1:g]);
   end

   assign v_in = (en & {v_ff[NS-2:0], req_valid}) | (~en & v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = ~en[S_IN];
   assign rsp_valid = v_ff[S_OUT];

   // ---------------------------------------------------------------
   // datapath registers
   // ---------------------------------------------------------------
   logic signed [CW-1:0] pt_ff   [2][3];
   logic signed [CW-1:0] pt_in   [2][3];
   logic signed [PW-1:0] prod_ff [2][3][3];
   logic signed [PW-1:0] prod_in [2][3][3];
   logic signed [HW-1:0] h_ff    [2][3];
   logic signed [HW-1:0] h_in    [2][3];
   logic [NW-1:0]        num_ff  [4];
   logic [NW-1:0]        num_in  [4];
   logic [HW-1:0]        den_ff  [2];
   logic [HW-1:0]        den_in  [2];
   logic [3:0]           neg_in;
   logic                 zero_in;
   logic [NW-1:0]        quo     [4];
   logic signed [QW-1:0] qs_ff   [4];
   logic signed [QW-1:0] qs_in   [4];
   logic signed [DW-1:0] dif_ff  [2];
   logic signed [DW-1:0] dif_in  [2];
   logic [DW-1:0]        magn    [2];
   logic [31:0]          dm_ff   [2];
   logic [31:0]          dm_in   [2];
   logic                 big_in;
   logic [RAD_BITS-1:0]  sq_ff   [2];
   logic [RAD_BITS-1:0]  sq_in   [2];
   logic [RAD_BITS:0]    sum_in;
   logic [RAD_BITS-1:0]  rad_ff;
   logic [ROOT_BITS-1:0] root;
   sb_type               sb_ff   [S_OUT];
   sb_type               sb_in   [S_OUT];
   rsp_type              rsp_ff;
   rsp_type              rsp_in;

   // low COORD_BITS bits of each field, two's complement
   assign pt_in[0][0] = CW'(48'(req_data.first_x));
   assign pt_in[0][1] = CW'(48'(req_data.first_y));
   assign pt_in[0][2] = CW'(48'(req_data.first_z));
   assign pt_in[1][0] = CW'(48'(req_data.second_x));
   assign pt_in[1][1] = CW'(48'(req_data.second_y));
   assign pt_in[1][2] = CW'(48'(req_data.second_z));

   // exact products, one multiplier each
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_in[p][r][c] = PW'(pt_ff[p][c]) * PW'(coef[r*3+c]);
            end
         end
      end
   end

   // h = K * p, exact
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         for (int r = 0; r < 3; r++) begin
            h_in[p][r] = HW'(prod_ff[p][r][0]) + HW'(prod_ff[p][r][1])
                       + HW'(prod_ff[p][r][2]);
         end
      end
   end

   // lanes: x of first, y of first, x of second, y of second
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         den_in[p] = $unsigned(h_ff[p][2][HW-1] ? -h_ff[p][2] : h_ff[p][2]);
      end
      for (int l = 0; l < 4; l++) begin
         num_in[l] = NW'($unsigned(h_ff[l>>1][l&1][HW-1] ? -h_ff[l>>1][l&1]
                                                          : h_ff[l>>1][l&1]))
                     << FRAC_BITS;
         neg_in[l] = h_ff[l>>1][l&1][HW-1] ^ h_ff[l>>1][2][HW-1];
      end
      zero_in = (h_ff[0][2] == '0) || (h_ff[1][2] == '0);
   end

   for (genvar l = 0; l < 4; l++) begin : g_div
      pre_div #(
         .HW (HW),
         .NW (NW)
      ) u_div (
         .clock (clock),
         .en    (en[S_DIV +: NW]),
         .num   (num_ff[l]),
         .den   (den_ff[l >> 1]),
         .quo   (quo[l])
      );
   end

   // quotient truncated toward zero, sign applied after the divide
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         qs_in[l] = sb_ff[S_SGN-1].neg[l] ? -$signed({1'b0, quo[l]})
                                          : $signed({1'b0, quo[l]});
      end
      for (int a = 0; a < 2; a++) begin
         dif_in[a] = DW'(qs_ff[a]) - DW'(qs_ff[a+2]);
         magn[a]   = $unsigned(dif_ff[a][DW-1] ? -dif_ff[a] : dif_ff[a]);
         dm_in[a]  = magn[a][31:0];
         sq_in[a]  = RAD_BITS'(dm_ff[a]) * RAD_BITS'(dm_ff[a]);
      end
      // distance can only fit when both deltas are under 2^32
      big_in = (|magn[0][DW-1:32]) || (|magn[1][DW-1:32]);
      sum_in = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]};
   end

   pre_sqrt u_sqrt (
      .clock (clock),
      .en    (en[S_RT +: ROOT_BITS]),
      .rad   (rad_ff),
      .root  (root)
   );

   // sideband follows the item stage by stage
   always_comb begin
      sb_in[S_IN]       = '0;
      sb_in[S_IN].stamp = req_data.stamp;
      for (int k = 1; k < S_OUT; k++) begin
         sb_in[k] = sb_ff[k-1];
      end
      sb_in[S_ABS].fault = zero_in;
      sb_in[S_ABS].neg   = neg_in;
      sb_in[S_MAG].sat   = sb_ff[S_MAG-1].sat | big_in;
      sb_in[S_ADD].sat   = sb_ff[S_ADD-1].sat | sum_in[RAD_BITS];
   end

   // zero depth or an oversize distance reads as all ones
   always_comb begin
      rsp_in.stamp_out    = sb_ff[S_OUT-1].stamp;
      rsp_in.divide_fault = sb_ff[S_OUT-1].fault;
      rsp_in.pixel_error  = (sb_ff[S_OUT-1].fault || sb_ff[S_OUT-1].sat) ? '1 : root;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < S_OUT; k++) begin
         if (en[k]) begin
            sb_ff[k] <= sb_in[k];
         end
      end
      if (en[S_IN]) begin
         pt_ff <= pt_in;
      end
      if (en[S_MUL]) begin
         prod_ff <= prod_in;
      end
      if (en[S_SUM]) begin
         h_ff <= h_in;
      end
      if (en[S_ABS]) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
      if (en[S_SGN]) begin
         qs_ff <= qs_in;
      end
      if (en[S_DIF]) begin
         dif_ff <= dif_in;
      end
      if (en[S_MAG]) begin
         dm_ff <= dm_in;
      end
      if (en[S_SQR]) begin
         sq_ff <= sq_in;
      end
      if (en[S_ADD]) begin
         rad_ff <= sum_in[RAD_BITS-1:0];
      end
      if (en[S_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: hw/rtl/pre_checker.sv
// port-level checks of the pinhole reprojection error block, bound to the top
// depends on pre_pkg and pinhole_reprojection_error_top_defines.svh
`include "pinhole_reprojection_error_top_defines.svh"

module pre_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pre_pkg::rsp_type rsp_data
);
   import pre_pkg::*;

   // no item survives a reset
   `PRE_CHECK_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "item out right after reset")

   // input backs up only when the whole pipe is full behind a stalled output
   `PRE_CHECK(a_stall_cause, req_stall |-> rsp_valid && rsp_stall,
              "input stall without output stall")

   // zero depth always reports the saturated distance
   `PRE_CHECK(a_fault_sat, rsp_valid && rsp_data.divide_fault |-> rsp_data.pixel_error == '1,
              "fault without all-ones error")

   // a held result stays put
   `PRE_CHECK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data),
              "stalled result changed")

endmodule

bind pinhole_reprojection_error_top pre_checker u_pre_checker (.*);

FILE: verif/pre_checker.sv
// result checker for the pinhole reprojection error block: tracks the camera matrix,
// predicts each result and compares it against the result channel; depends on pre_pkg
`timescale 1ns / 1ps

module pre_result_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  pre_pkg::req_type                  req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  pre_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [pre_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [pre_pkg::CSR_DATA_BITS-1:0] csr_data,
   output int                                fail_count,
   output int                                pending,
   output int                                checked
);
   import pre_pkg::*;

   localparam int NUM_REGS = 5;

   logic [63:0] cam_matrix [NUM_REGS];
   rsp_type     distance_fifo [$];

   function automatic logic [127:0] mag(input logic signed [127:0] v);
      return v[127] ? -v : v;
   endfunction

   // h_i scaled by 2^16 over h2, truncated toward zero
   function automatic logic signed [127:0] pixel_coord(input logic signed [127:0] hv,
                                                       input logic signed [127:0] hz);
      logic [127:0] q;
      q = (mag(hv) << 16) / mag(hz);
      return (hv[127] != hz[127]) ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitv;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v    = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic rsp_type predict_distance(input req_type it);
      logic signed [127:0] k [9];
      logic signed [127:0] pa [3];
      logic signed [127:0] pb [3];
      logic signed [127:0] ha [3];
      logic signed [127:0] hb [3];
      logic [127:0]        dx;
      logic [127:0]        dy;
      logic [64:0]         sq;
      rsp_type             res;
      for (int i = 0; i < 9; i++) begin
         k[i] = (i % 2) ? $signed(cam_matrix[i / 2][63:32])
                        : $signed(cam_matrix[i / 2][31:0]);
      end
      pa[0] = it.first_x;  pa[1] = it.first_y;  pa[2] = it.first_z;
      pb[0] = it.second_x; pb[1] = it.second_y; pb[2] = it.second_z;
      for (int r = 0; r < 3; r++) begin
         ha[r] = 0;
         hb[r] = 0;
         for (int c = 0; c < 3; c++) begin
            ha[r] = ha[r] + k[r * 3 + c] * pa[c];
            hb[r] = hb[r] + k[r * 3 + c] * pb[c];
         end
      end
      res.stamp_out    = it.stamp;
      res.pixel_error  = '1;
      res.divide_fault = 1'b1;
      if (ha[2] != 0 && hb[2] != 0) begin
         res.divide_fault = 1'b0;
         dx = mag(pixel_coord(ha[0], ha[2]) - pixel_coord(hb[0], hb[2]));
         dy = mag(pixel_coord(ha[1], ha[2]) - pixel_coord(hb[1], hb[2]));
         if (dx <= 128'hFFFF_FFFF && dy <= 128'hFFFF_FFFF) begin
            sq = {1'b0, dx[63:0] * dx[63:0]} + {1'b0, dy[63:0] * dy[63:0]};
            if (!sq[64]) res.pixel_error = 32'(floor_sqrt(sq[63:0]));
         end
      end
      return res;
   endfunction

   assign pending = distance_fifo.size();

   initial begin
      fail_count = 0;
      checked    = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) cam_matrix[i] <= '0;
      end else begin
         if (csr_valid && csr_ready && csr_index < NUM_REGS) begin
            cam_matrix[csr_index] <= (csr_index == CSR_K22) ? {32'd0, csr_data[31:0]}
                                                            : csr_data;
         end
         if (req_valid && !req_stall) distance_fifo.push_back(predict_distance(req_data));
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (distance_fifo.size() == 0) begin
               $error("result with no item outstanding, stamp %h", rsp_data.stamp_out);
               fail_count++;
            end else begin
               want = distance_fifo.pop_front();
               if (rsp_data.stamp_out !== want.stamp_out) begin
                  $error("stamp_out: expected %h actual %h", want.stamp_out, rsp_data.stamp_out);
                  fail_count++;
               end
               if (rsp_data.pixel_error !== want.pixel_error) begin
                  $error("pixel_error: expected %h actual %h",
                         want.pixel_error, rsp_data.pixel_error);
                  fail_count++;
               end
               if (rsp_data.divide_fault !== want.divide_fault) begin
                  $error("divide_fault: expected %b actual %b",
                         want.divide_fault, rsp_data.divide_fault);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

FILE: verif/tb_top.sv
// testbench top for the pinhole reprojection error block: clock, reset, item and
// matrix stimulus, result-side stalls and verdict; depends on pre_pkg and pre_checker
`timescale 1ns / 1ps

module tb_top;
   import pre_pkg::*;

   // pipeline is 124 deep at default parameters, leave margin
   localparam int DRAIN_CYCLES = 200;
   localparam int NUM_PHASES   = 6;
   localparam int PHASE_ITEMS  = 230;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_type                  rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   int fail_count;
   int pending;
   int checked;
   int sent;
   bit quiet;       // no idling on either side
   bit hold_long;   // ask the receiver for one long hold-off

   pinhole_reprojection_error_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   pre_result_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending), .checked(checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side: random stall bursts, one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_long) begin
            // long enough for the pipeline to fill and push back on the sender
            rsp_stall = 1'b1;
            repeat (600) @(negedge clock);
            hold_long = 1'b0;
            rsp_stall = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 16) - 1) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // one item, held until accepted; valid stays high for a back-to-back item
   task automatic send_item(input req_type it);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = it;
      do @(posedge clock); while (req_stall);
      sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // wait for every outstanding result, then let the pipe empty
   task automatic drain();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic load_matrix(input logic [31:0] k [9]);
      write_csr(CSR_K00_K01, {k[1], k[0]});
      write_csr(CSR_K02_K10, {k[3], k[2]});
      write_csr(CSR_K11_K12, {k[5], k[4]});
      write_csr(CSR_K20_K21, {k[7], k[6]});
      // upper half of the last register is not stored
      write_csr(CSR_K22, {$urandom(), k[8]});
   endtask

   function automatic req_type make_item(input logic [31:0] ax, ay, az, bx, by, bz);
      req_type it;
      it.stamp    = {$urandom(), $urandom()};
      it.first_x  = ax; it.first_y  = ay; it.first_z  = az;
      it.second_x = bx; it.second_y = by; it.second_z = bz;
      return it;
   endfunction

   // coefficient mix: realistic intrinsics, small values, extremes, raw noise
   function automatic logic [31:0] rand_coef(input int slot);
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'd0;
         4, 5:    return $urandom();
         default: begin
            if (slot == 0 || slot == 4) return $urandom_range(200, 2000) << 16;
            if (slot == 8) return 32'h0001_0000;
            return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20)
                                        : -$urandom_range(0, 1 << 20);
         end
      endcase
   endfunction

   function automatic logic [31:0] rand_coord(input bit depth);
      case ($urandom_range(0, 7))
         0:       return $urandom();
         1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2:       return depth ? 32'd0 : $urandom_range(0, 15);
         default: begin
            // metric-scale points in front of the camera
            if (depth) return $urandom_range(1 << 14, 50 << 16);
            return $urandom_range(0, 1) ? $urandom_range(0, 10 << 16)
                                        : -$urandom_range(0, 10 << 16);
         end
      endcase
   endfunction

   initial begin
      logic [31:0] kmat [9];
      req_type     it;
      sent      = 0;
      quiet     = 1'b0;
      hold_long = 1'b0;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      reset     = 1'b1;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // matrix still zero after reset: every item is a divide fault
      send_item(make_item(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                          32'h0004_0000, 32'h0005_0000, 32'h0006_0000));
      send_item(make_item('1, '1, '1, '0, '0, '0));
      drain();

      // plain pinhole: f = 500, principal point (320, 240)
      kmat = '{32'd500 << 16, 0, 32'd320 << 16, 0, 32'd500 << 16, 32'd240 << 16,
               0, 0, 32'h0001_0000};
      load_matrix(kmat);
      // writes past the last register must leave the matrix alone
      write_csr(3'd5, '1);
      write_csr(3'd7, '1);
      send_item(make_item(32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
                          32'h0001_0000, 32'h0001_0000, 32'h0002_0000));  // same point
      send_item(make_item(32'h0001_0000, 0, 32'h0001_0000,
                          0, 0, 32'h0001_0000));                          // one unit apart
      send_item(make_item(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000));     // first depth zero
      send_item(make_item(0, 0, 32'h0001_0000, 0, 0, 0));                 // second depth zero
      send_item(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'd1,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'd1));          // saturates
      send_item(make_item(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000,
                          32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000));  // behind camera
      send_item(make_item(32'd1, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1));
      drain();

      // extreme coefficients
      foreach (kmat[i]) kmat[i] = 32'h8000_0000;
      load_matrix(kmat);
      send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
      send_item(make_item(32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF, 32'd5, 32'd7));
      drain();
      foreach (kmat[i]) kmat[i] = (i % 2) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
      load_matrix(kmat);
      send_item(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'd0, 32'd0, 32'h0000_0001));
      send_item(make_item(32'h8000_0000, 32'd3, 32'hFFFF_FFFF,
                          32'h0001_0000, 32'd0, 32'h8000_0000));
      drain();

      // random phases, each on a fresh matrix
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         foreach (kmat[i]) kmat[i] = rand_coef(i);
         load_matrix(kmat);
         quiet = (ph == NUM_PHASES - 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 2 && n == 20) hold_long = 1'b1;
            // sender stops until every result is back, then resumes
            if (ph == 3 && n == PHASE_ITEMS / 2) begin
               req_valid = 1'b0;
               while (pending != 0) @(negedge clock);
            end
            it = make_item(rand_coord(0), rand_coord(0), rand_coord(1),
                           rand_coord(0), rand_coord(0), rand_coord(1));
            // one pair in three made nearby, so its distance stays in range
            if ($urandom_range(0, 2) == 0) begin
               it.second_x = it.first_x + $urandom_range(0, 1 << 12);
               it.second_y = it.first_y - $urandom_range(0, 1 << 12);
               it.second_z = it.first_z;
            end
            send_item(it);
         end
         drain();
      end

      $display("covered %0d items over %0d matrix settings, %0d results checked",
               sent, NUM_PHASES + 4, checked);
      $display("directed zero-depth, saturation and extreme cases plus random points");
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
